// ----- rtl/gwps_pkg.sv -----
// Package for the Gaussian window part score block: beat types, unit request types,
// sequencer states, command and register codes, fixed-point constants and the exp table.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package gwps_pkg;

	localparam int MAX_HALF_RANGE_DEF = 8;
	localparam int MAX_CANDS_DEF      = 8;

	// divider: dividend wide enough for a squared window distance shifted by 23
	localparam int DIV_W = 44;
	localparam int DSR_W = 24;
	localparam int EXP_W = 17;

	localparam logic [16:0] LOG2E_Q16       = 17'd94548;
	localparam logic [14:0] INV_SQRT2PI_Q16 = 15'd26145;
	localparam logic [16:0] FLOOR_EXP_Q16   = 17'd728;

	localparam logic [1:0] CMD_LOAD_PIXEL = 2'd0;
	localparam logic [1:0] CMD_LOAD_CAND  = 2'd1;
	localparam logic [1:0] CMD_COMPUTE    = 2'd2;

	// word index of the configuration registers (paddr[2])
	localparam logic REG_MAP_SIGMA = 1'b0;
	localparam logic REG_NUM_CANDS = 1'b1;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [8:0]         index;
		logic signed [15:0] pixel_value;
		logic signed [7:0]  cand_offset;
		logic [3:0]         half_range;
		logic [11:0]        deform_sigma;
		logic [9:0]         center_row;
		logic [9:0]         center_col;
	} item_t;

	typedef struct packed {
		logic [31:0]        fit_prior;
		logic [15:0]        deform_prob;
		logic signed [15:0] grad_row;
		logic signed [15:0] grad_col;
		logic signed [15:0] pos_row;
		logic signed [15:0] pos_col;
		logic [5:0]         pair_index;
		logic               last;
	} result_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] xq;
	} exp_req_t;

	typedef struct packed {
		logic             done;
		logic [EXP_W-1:0] e;
	} exp_rsp_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RDC1,
		S_RDC2,
		S_RDC3,
		S_XDIV,
		S_XDIV_W,
		S_EXP_W,
		S_GDIV,
		S_GDIV_W,
		S_RDIV,
		S_RDIV_W,
		S_W_DIST,
		S_W_SEL,
		S_MUL,
		S_ACC,
		S_PROB,
		S_EMIT
	} state_t;

	// 2^-(k/16) in Q16
	function automatic logic [16:0] pow2neg(input logic [4:0] k);
		logic [16:0] v;
		case (k)
			5'd0:    v = 17'd65536;
			5'd1:    v = 17'd62757;
			5'd2:    v = 17'd60097;
			5'd3:    v = 17'd57549;
			5'd4:    v = 17'd55109;
			5'd5:    v = 17'd52772;
			5'd6:    v = 17'd50535;
			5'd7:    v = 17'd48393;
			5'd8:    v = 17'd46341;
			5'd9:    v = 17'd44376;
			5'd10:   v = 17'd42495;
			5'd11:   v = 17'd40693;
			5'd12:   v = 17'd38968;
			5'd13:   v = 17'd37316;
			5'd14:   v = 17'd35734;
			5'd15:   v = 17'd34219;
			5'd16:   v = 17'd32768;
			default: v = 17'd32768;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/gaussian_window_part_score.sv -----
// Top level of the Gaussian window part score block: configuration registers,
// sequencer core, shared divider and exp unit. Depends on gwps_pkg and the gwps_* modules.
//
//   channel | dir | handshake                       | beat
//   cmd     | in  | cmd_valid / cmd_stall           | gwps_pkg::item_t
//   res     | out | res_valid / res_stall           | gwps_pkg::result_t
//   apb     | in  | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
// Pixel and candidate loads never raise cmd_stall; a compute beat holds cmd_stall high
// until its last result is loaded into the output register.
// Each result runs the two deformation Gaussians (three divides and an exp each), then per
// window pixel two divides and an exp (within three sigma) or one divide (floor weight),
// then forms and loads the result; the passes of the shared divider, used once or twice
// per pixel, take most of this time.
// Reset clears the sequencer and the output valid; the stores need no clearing pass.
// A stalled result holds in the output register while the sequencer waits on it.
`default_nettype none

module gaussian_window_part_score #(
	parameter int MAX_HALF_RANGE = gwps_pkg::MAX_HALF_RANGE_DEF,
	parameter int MAX_CANDS      = gwps_pkg::MAX_CANDS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	input  wire gwps_pkg::item_t   cmd_beat,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output gwps_pkg::result_t      res_beat
);

	logic [11:0] map_sigma_q;
	logic [3:0]  num_cands_q;
	logic        cfg_wr;

	gwps_pkg::div_req_t div_req;
	gwps_pkg::div_rsp_t div_rsp;
	gwps_pkg::exp_req_t exp_req;
	gwps_pkg::exp_rsp_t exp_rsp;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_sigma_q <= 12'd256;
			num_cands_q <= 4'd8;
		end else if (cfg_wr) begin
			if (paddr[2] == gwps_pkg::REG_MAP_SIGMA) begin
				map_sigma_q <= pwdata[11:0];
			end else begin
				num_cands_q <= pwdata[3:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == gwps_pkg::REG_NUM_CANDS) begin
			prdata = {28'd0, num_cands_q};
		end else begin
			prdata = {20'd0, map_sigma_q};
		end
	end

	gwps_core #(
		.MAX_HALF_RANGE(MAX_HALF_RANGE),
		.MAX_CANDS(MAX_CANDS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.map_sigma(map_sigma_q),
		.num_cands(num_cands_q),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_beat(cmd_beat),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_beat(res_beat),
		.div_req(div_req),
		.div_rsp(div_rsp),
		.exp_req(exp_req),
		.exp_rsp(exp_rsp)
	);

	gwps_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	gwps_exp u_exp (
		.clk(clk),
		.arst_n(arst_n),
		.req(exp_req),
		.rsp(exp_rsp)
	);

endmodule

`default_nettype wire

// ----- rtl/gwps_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Uses gwps_pkg request/response types.
`default_nettype none

module gwps_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire gwps_pkg::div_req_t  req,
	output gwps_pkg::div_rsp_t       rsp
);

	localparam int DW  = gwps_pkg::DIV_W;
	localparam int RW  = gwps_pkg::DSR_W;
	localparam int CTW = $clog2(DW);

	logic          busy_q;
	logic          done_q;
	logic [CTW-1:0] cnt_q;
	logic [DW-1:0] dvd_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] dsr_q;

	logic [RW:0]   trial;
	logic          ge;
	logic [RW-1:0] rem_d;

	always_comb begin
		trial = {rem_q, dvd_q[DW-1]};
		ge    = trial >= {1'b0, dsr_q};
		rem_d = ge ? RW'(trial - {1'b0, dsr_q}) : trial[RW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CTW'(1);
				if (cnt_q == CTW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in from the bottom as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], ge};
			rem_q <= rem_d;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

`default_nettype wire

// ----- rtl/gwps_exp.sv -----
// exp(-x) in Q16 for x in Q16: log2 scaling, table with linear interpolation, shift.
// Three registered stages; uses gwps_pkg types, constants and the pow2neg table.
`default_nettype none

module gwps_exp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire gwps_pkg::exp_req_t  req,
	output gwps_pkg::exp_rsp_t       rsp
);

	localparam int DW = gwps_pkg::DIV_W;

	logic        v_s1, v_s2, v_s3;
	logic        zero_s1, zero_s2;
	logic [36:0] p_s1;
	logic [16:0] t0_s2;
	logic [23:0] prod_s2;
	logic [4:0]  n_s2;
	logic [16:0] e_s3;

	logic [20:0] y;
	logic [4:0]  n;
	logic [3:0]  k;
	logic [11:0] r;
	logic [16:0] t0, t1;
	logic [16:0] m;

	always_comb begin
		y  = p_s1[36:16];
		n  = y[20:16];
		k  = y[15:12];
		r  = y[11:0];
		t0 = gwps_pkg::pow2neg({1'b0, k});
		t1 = gwps_pkg::pow2neg(5'({1'b0, k}) + 5'd1);
		m  = t0_s2 - 17'(prod_s2 >> 12);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		// anything at or above 2^20 lands beyond 2^-16 and reads as zero
		zero_s1 <= |req.xq[DW-1:20];
		p_s1    <= 37'(req.xq[19:0]) * 37'(gwps_pkg::LOG2E_Q16);
		zero_s2 <= zero_s1 || (n >= 5'd17);
		t0_s2   <= t0;
		prod_s2 <= 24'(12'(t0 - t1)) * 24'(r);
		n_s2    <= n;
		e_s3    <= zero_s2 ? '0 : (m >> n_s2);
	end

	assign rsp.done = v_s3;
	assign rsp.e    = e_s3;

endmodule

`default_nettype wire

// ----- rtl/gwps_core.sv -----
// Sequencer, window and candidate stores, accumulator and result register.
// Drives the shared divider and exp unit; uses gwps_pkg types, states and constants.
`default_nettype none

module gwps_core #(
	parameter int MAX_HALF_RANGE = gwps_pkg::MAX_HALF_RANGE_DEF,
	parameter int MAX_CANDS      = gwps_pkg::MAX_CANDS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [11:0]        map_sigma,
	input  wire logic [3:0]         num_cands,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire gwps_pkg::item_t    cmd_beat,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output gwps_pkg::result_t       res_beat,
	output gwps_pkg::div_req_t      div_req,
	input  wire gwps_pkg::div_rsp_t div_rsp,
	output gwps_pkg::exp_req_t      exp_req,
	input  wire gwps_pkg::exp_rsp_t exp_rsp
);

	localparam int SIDE      = 2 * MAX_HALF_RANGE + 1;
	localparam int WIN_DEPTH = SIDE * SIDE;
	localparam int WIX_W     = $clog2(WIN_DEPTH);
	localparam int OW        = $clog2(SIDE);
	localparam int CW        = (MAX_CANDS > 1) ? $clog2(MAX_CANDS) : 1;
	localparam int CNT_W     = $clog2(MAX_CANDS + 1);
	localparam int DW        = gwps_pkg::DIV_W;
	localparam int RW        = gwps_pkg::DSR_W;

	gwps_pkg::state_t state_q, state_d;

	logic [15:0] win_mem [WIN_DEPTH];
	logic [7:0]  cand_mem [MAX_CANDS];
	logic [15:0] wrd_q;
	logic [7:0]  crd_q;
	logic [CW-1:0] crd_addr;

	logic [CW-1:0]    p1_q, p2_q;
	logic [CNT_W-1:0] cnt_q;
	logic [5:0]       k_q;
	logic [3:0]       hr_q;
	logic [11:0]      ds_q, ms_q;
	logic [23:0]      ds2_q, s_q;
	logic [9:0]       crow_q, ccol_q;
	logic signed [7:0] cc_q, cr_q;
	logic             ax_q, win_q;
	logic [16:0]      e_q;
	logic [31:0]      g_row_q, g_col_q, w_q;
	logic [15:0]      grad_row_q, grad_col_q;
	logic [OW-1:0]    ow_q, oh_q;
	logic [WIX_W-1:0] idx_q;
	logic [19:0]      d_q;
	logic [47:0]      mul_q;
	logic [57:0]      acc_q;
	logic [63:0]      prob_q;
	logic             out_valid_q;
	gwps_pkg::result_t out_q;

	logic        fire;
	logic        slot_free;
	logic        emit;
	logic        last_pair, p2_end, win_end;
	logic        near;
	logic signed [7:0] c_ax;
	logic [7:0]  c_abs;
	logic [15:0] c_sq;
	logic signed [11:0] dc, dr;
	logic [23:0] dc_sq, dr_sq;
	logic [19:0] d_sum;
	logic [3:0]  hr_in;
	logic [11:0] ds_in, ms_in;
	logic [3:0]  cnt_in;
	logic [15:0] grad_val;
	logic [OW-1:0] two_hr;
	logic [15:0] prob_sat;
	logic [31:0] fit_sat;

	assign fire      = cmd_valid && !cmd_stall;
	assign slot_free = !out_valid_q || !res_stall;

	always_comb begin
		hr_in  = (cmd_beat.half_range > 4'(MAX_HALF_RANGE)) ? 4'(MAX_HALF_RANGE)
			: cmd_beat.half_range;
		ds_in  = (cmd_beat.deform_sigma == 12'd0) ? 12'd1 : cmd_beat.deform_sigma;
		ms_in  = (map_sigma == 12'd0) ? 12'd1 : map_sigma;
		cnt_in = (num_cands > 4'(MAX_CANDS)) ? 4'(MAX_CANDS) : num_cands;

		c_ax  = ax_q ? cc_q : cr_q;
		c_abs = c_ax[7] ? 8'(-c_ax) : 8'(c_ax);
		c_sq  = 16'(c_abs) * 16'(c_abs);

		two_hr  = OW'({hr_q, 1'b0});
		win_end = (oh_q == two_hr) && (ow_q == two_hr);
		p2_end  = CNT_W'(p2_q) == cnt_q - CNT_W'(1);
		last_pair = p2_end && (CNT_W'(p1_q) == cnt_q - CNT_W'(1));

		// distances from the candidate point to the pixel, Q.4 each axis
		dc    = 12'(cc_q) + (12'(hr_q) << 4) - (12'(ow_q) << 4);
		dr    = 12'(cr_q) + (12'(hr_q) << 4) - (12'(oh_q) << 4);
		dc_sq = 24'(dc * dc);
		dr_sq = 24'(dr * dr);
		d_sum = 20'(dc_sq) + 20'(dr_sq);
		near  = {d_q, 8'b0} < ((28'(s_q) << 3) + 28'(s_q));

		if (c_ax[7]) begin
			grad_val = 16'(-((div_rsp.quotient > DW'(32768)) ? 17'd32768
				: 17'(div_rsp.quotient)));
		end else begin
			grad_val = (div_rsp.quotient > DW'(32767)) ? 16'h7FFF
				: 16'(div_rsp.quotient);
		end

		prob_sat = (|prob_q[63:48]) ? 16'hFFFF : prob_q[47:32];
		fit_sat  = (|acc_q[57:48]) ? 32'hFFFF_FFFF : acc_q[47:16];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gwps_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		cmd_stall        = 1'b1;
		emit             = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = ds2_q;
		exp_req.start    = 1'b0;
		exp_req.xq       = div_rsp.quotient;
		case (state_q)
			gwps_pkg::S_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid && cmd_beat.cmd == gwps_pkg::CMD_COMPUTE && cnt_in != 4'd0) begin
					state_d = gwps_pkg::S_RDC1;
				end
			end
			gwps_pkg::S_RDC1: state_d = gwps_pkg::S_RDC2;
			gwps_pkg::S_RDC2: state_d = gwps_pkg::S_RDC3;
			gwps_pkg::S_RDC3: state_d = gwps_pkg::S_XDIV;
			gwps_pkg::S_XDIV: begin
				div_req.start = 1'b1;
				if (win_q) begin
					div_req.dividend = DW'({d_q, 23'b0});
					div_req.divisor  = s_q;
				end else begin
					div_req.dividend = DW'({c_sq, 23'b0});
				end
				state_d = gwps_pkg::S_XDIV_W;
			end
			gwps_pkg::S_XDIV_W: begin
				if (div_rsp.done) begin
					exp_req.start = 1'b1;
					state_d       = gwps_pkg::S_EXP_W;
				end
			end
			gwps_pkg::S_EXP_W: begin
				if (exp_rsp.done) begin
					state_d = gwps_pkg::S_GDIV;
				end
			end
			gwps_pkg::S_GDIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = DW'(32'(e_q) * 32'(gwps_pkg::INV_SQRT2PI_Q16));
				div_req.divisor  = win_q ? RW'(ms_q) : RW'(ds_q);
				state_d          = gwps_pkg::S_GDIV_W;
			end
			gwps_pkg::S_GDIV_W: begin
				if (div_rsp.done) begin
					state_d = win_q ? gwps_pkg::S_MUL : gwps_pkg::S_RDIV;
				end
			end
			gwps_pkg::S_RDIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = DW'({c_abs, 20'b0});
				state_d          = gwps_pkg::S_RDIV_W;
			end
			gwps_pkg::S_RDIV_W: begin
				if (div_rsp.done) begin
					state_d = ax_q ? gwps_pkg::S_W_DIST : gwps_pkg::S_XDIV;
				end
			end
			gwps_pkg::S_W_DIST: state_d = gwps_pkg::S_W_SEL;
			gwps_pkg::S_W_SEL: begin
				state_d = near ? gwps_pkg::S_XDIV : gwps_pkg::S_GDIV;
			end
			gwps_pkg::S_MUL: state_d = gwps_pkg::S_ACC;
			gwps_pkg::S_ACC: begin
				state_d = win_end ? gwps_pkg::S_PROB : gwps_pkg::S_W_DIST;
			end
			gwps_pkg::S_PROB: state_d = gwps_pkg::S_EMIT;
			gwps_pkg::S_EMIT: begin
				if (slot_free) begin
					emit    = 1'b1;
					state_d = last_pair ? gwps_pkg::S_IDLE : gwps_pkg::S_RDC1;
				end
			end
			default: state_d = gwps_pkg::S_IDLE;
		endcase
	end

	// stores
	always_ff @(posedge clk) begin
		if (state_q == gwps_pkg::S_IDLE && fire && cmd_beat.cmd == gwps_pkg::CMD_LOAD_PIXEL
				&& 32'(cmd_beat.index) < 32'(WIN_DEPTH)) begin
			win_mem[WIX_W'(32'(cmd_beat.index))] <= cmd_beat.pixel_value[15] ? 16'd0
				: cmd_beat.pixel_value;
		end
		wrd_q <= win_mem[idx_q];
	end

	assign crd_addr = (state_q == gwps_pkg::S_RDC2) ? p2_q : p1_q;

	always_ff @(posedge clk) begin
		if (state_q == gwps_pkg::S_IDLE && fire && cmd_beat.cmd == gwps_pkg::CMD_LOAD_CAND
				&& 32'(cmd_beat.index) < 32'(MAX_CANDS)) begin
			cand_mem[CW'(32'(cmd_beat.index))] <= cmd_beat.cand_offset;
		end
		crd_q <= cand_mem[crd_addr];
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			gwps_pkg::S_IDLE: begin
				if (fire && cmd_beat.cmd == gwps_pkg::CMD_COMPUTE) begin
					hr_q   <= hr_in;
					ds_q   <= ds_in;
					ms_q   <= ms_in;
					ds2_q  <= 24'(ds_in) * 24'(ds_in);
					s_q    <= 24'(ms_in) * 24'(ms_in);
					crow_q <= cmd_beat.center_row;
					ccol_q <= cmd_beat.center_col;
					cnt_q  <= CNT_W'(cnt_in);
					p1_q   <= '0;
					p2_q   <= '0;
					k_q    <= '0;
				end
			end
			gwps_pkg::S_RDC2: cc_q <= crd_q;
			gwps_pkg::S_RDC3: begin
				cr_q  <= crd_q;
				ax_q  <= 1'b0;
				win_q <= 1'b0;
			end
			gwps_pkg::S_EXP_W: begin
				if (exp_rsp.done) begin
					e_q <= exp_rsp.e;
				end
			end
			gwps_pkg::S_GDIV_W: begin
				if (div_rsp.done) begin
					if (win_q) begin
						w_q <= div_rsp.quotient[31:0];
					end else if (ax_q) begin
						g_col_q <= div_rsp.quotient[31:0];
					end else begin
						g_row_q <= div_rsp.quotient[31:0];
					end
				end
			end
			gwps_pkg::S_RDIV_W: begin
				if (div_rsp.done) begin
					if (ax_q) begin
						grad_col_q <= grad_val;
						win_q      <= 1'b1;
						ow_q       <= '0;
						oh_q       <= '0;
						idx_q      <= '0;
						acc_q      <= '0;
					end else begin
						grad_row_q <= grad_val;
						ax_q       <= 1'b1;
					end
				end
			end
			gwps_pkg::S_W_DIST: d_q <= d_sum;
			gwps_pkg::S_W_SEL: begin
				if (!near) begin
					e_q <= gwps_pkg::FLOOR_EXP_Q16;
				end
			end
			gwps_pkg::S_MUL: mul_q <= 48'(w_q) * 48'(wrd_q);
			gwps_pkg::S_ACC: begin
				acc_q <= acc_q + 58'(mul_q);
				idx_q <= idx_q + WIX_W'(1);
				if (oh_q == two_hr) begin
					oh_q <= '0;
					ow_q <= ow_q + OW'(1);
				end else begin
					oh_q <= oh_q + OW'(1);
				end
			end
			gwps_pkg::S_PROB: prob_q <= 64'(g_col_q) * 64'(g_row_q);
			gwps_pkg::S_EMIT: begin
				if (slot_free) begin
					out_q.fit_prior   <= fit_sat;
					out_q.deform_prob <= prob_sat;
					out_q.grad_row    <= grad_row_q;
					out_q.grad_col    <= grad_col_q;
					out_q.pos_row     <= 16'({11'(crow_q) + 11'd1, 4'b0}) + 16'(cr_q);
					out_q.pos_col     <= 16'({11'(ccol_q) + 11'd1, 4'b0}) + 16'(cc_q);
					out_q.pair_index  <= k_q;
					out_q.last        <= last_pair;
					k_q <= k_q + 6'd1;
					if (p2_end) begin
						p2_q <= '0;
						p1_q <= p1_q + CW'(1);
					end else begin
						p2_q <= p2_q + CW'(1);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res_valid = out_valid_q;
	assign res_beat  = out_q;

endmodule

`default_nettype wire

// ----- rtl/gwps_checker.sv -----
// Port-level checks for gaussian_window_part_score, bound to the top level.
// Uses gwps_pkg beat types and command codes.
`default_nettype none

module gwps_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cmd_valid,
	input wire logic              cmd_stall,
	input wire gwps_pkg::item_t   cmd_beat,
	input wire logic              res_valid,
	input wire logic              res_stall,
	input wire gwps_pkg::result_t res_beat
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_beat))
		else $error("result beat changed while stalled");

	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && cmd_beat.cmd != gwps_pkg::CMD_COMPUTE |=> !cmd_stall)
		else $error("load beat did not complete in one cycle");

	a_res_during_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd_stall))
		else $error("result appeared outside a compute run");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && res_beat.last |=> !res_valid)
		else $error("result followed the last beat of a run");

endmodule

bind gaussian_window_part_score gwps_checker u_gwps_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cmd_valid(cmd_valid),
	.cmd_stall(cmd_stall),
	.cmd_beat(cmd_beat),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res_beat(res_beat)
);

`default_nettype wire

// ----- tb/sv/gaussian_window_part_score_tb.sv -----
// Self-checking testbench for gaussian_window_part_score: loads windows and offsets,
// runs compute beats across register settings and checks every result beat.
// Depends on gwps_pkg for the beat types and the command and register codes.
`default_nettype none

module gaussian_window_part_score_tb;

	localparam int HR_MAX    = gwps_pkg::MAX_HALF_RANGE_DEF;
	localparam int CANDS_MAX = gwps_pkg::MAX_CANDS_DEF;
	localparam int WIN_SIDE  = 2 * HR_MAX + 1;
	localparam int WIN_CELLS = WIN_SIDE * WIN_SIDE;
	localparam longint unsigned CYCLE_LIMIT = 4000000;
	localparam int SETTLE_CYCLES = 40;
	localparam logic [1:0] CMD_NOP = 2'd3;

	localparam longint unsigned POW2_TAB [17] = '{
		65536, 62757, 60097, 57549, 55109, 52772, 50535, 48393, 46341,
		44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
	};

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        cmd_valid;
	logic        cmd_stall;
	gwps_pkg::item_t   cmd_beat;
	logic        res_valid;
	logic        res_stall;
	gwps_pkg::result_t res_beat;

	gaussian_window_part_score dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_beat(cmd_beat),
		.res_valid(res_valid), .res_stall(res_stall), .res_beat(res_beat)
	);

	// shadow of the block's state
	logic [15:0] win_mem [WIN_CELLS];
	logic [7:0]  offs_mem [CANDS_MAX];
	logic [11:0] map_sigma_q;
	logic [3:0]  cand_count_q;

	gwps_pkg::result_t score_q [$];
	int      errors;
	bit      idle_on;
	int      stall_left;
	longint unsigned cycles;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result-side backpressure bursts
	always @(posedge clk) begin
		if (idle_on && stall_left == 0 && $urandom_range(7) == 0) begin
			stall_left <= $urandom_range(15, 1);
			res_stall  <= 1'b1;
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_left <= 0;
			res_stall  <= 1'b0;
		end
	end

	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", field, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		gwps_pkg::result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (score_q.size() == 0) begin
				report_mismatch("unexpected beat, pair_index", res_beat.pair_index, -1);
			end else begin
				want = score_q.pop_front();
				if (res_beat.fit_prior !== want.fit_prior)
					report_mismatch("fit_prior", res_beat.fit_prior, want.fit_prior);
				if (res_beat.deform_prob !== want.deform_prob)
					report_mismatch("deform_prob", res_beat.deform_prob, want.deform_prob);
				if (res_beat.grad_row !== want.grad_row)
					report_mismatch("grad_row", res_beat.grad_row, want.grad_row);
				if (res_beat.grad_col !== want.grad_col)
					report_mismatch("grad_col", res_beat.grad_col, want.grad_col);
				if (res_beat.pos_row !== want.pos_row)
					report_mismatch("pos_row", res_beat.pos_row, want.pos_row);
				if (res_beat.pos_col !== want.pos_col)
					report_mismatch("pos_col", res_beat.pos_col, want.pos_col);
				if (res_beat.pair_index !== want.pair_index)
					report_mismatch("pair_index", res_beat.pair_index, want.pair_index);
				if (res_beat.last !== want.last)
					report_mismatch("last", res_beat.last, want.last);
			end
		end
	end

	// exp(-x), x and result in Q16
	function automatic longint unsigned exp_neg(input longint unsigned xq);
		longint unsigned y, n, f, k, r, m;
		if (xq >= (64'd1 << 40))
			return 0;
		y = (xq * 94548) >> 16;
		n = y >> 16;
		if (n >= 17)
			return 0;
		f = y & 64'hFFFF;
		k = f >> 12;
		r = f & 64'hFFF;
		m = POW2_TAB[k] - (((POW2_TAB[k] - POW2_TAB[k + 1]) * r) >> 12);
		return m >> n;
	endfunction

	function automatic longint unsigned deform_gauss(input int off, input longint unsigned sig);
		longint unsigned c2, xq;
		c2 = longint'(off) * longint'(off);
		xq = (c2 << 23) / (sig * sig);
		return exp_neg(xq) * 26145 / sig;
	endfunction

	function automatic logic [15:0] log_grad(input int off, input longint unsigned sig);
		longint unsigned mag;
		int v;
		mag = (longint'(off < 0 ? -off : off) << 20) / (sig * sig);
		if (off < 0) begin
			if (mag > 32768) mag = 32768;
			v = -int'(mag);
		end else begin
			if (mag > 32767) mag = 32767;
			v = int'(mag);
		end
		return v[15:0];
	endfunction

	function automatic logic [31:0] weighted_sum(input int cc, input int cr, input int hr,
			input longint unsigned ms);
		longint unsigned s2, acc, d2, e, w;
		int side, dc, dr, idx;
		s2 = ms * ms;
		acc = 0;
		side = 2 * hr + 1;
		for (int jw = -hr; jw <= hr; jw++) begin
			dc = cc - 16 * jw;
			for (int jh = -hr; jh <= hr; jh++) begin
				dr = cr - 16 * jh;
				d2 = longint'(dc) * dc + longint'(dr) * dr;
				if (d2 * 256 < 9 * s2)
					e = exp_neg((d2 << 23) / s2);
				else
					e = 728;
				w = e * 26145 / ms;
				idx = (jw + hr) * side + (jh + hr);
				acc += w * win_mem[idx];
			end
		end
		acc >>= 16;
		return acc > 64'hFFFFFFFF ? 32'hFFFFFFFF : acc[31:0];
	endfunction

	// updates the shadow state and queues the results a beat will produce
	task automatic predict_beat(input gwps_pkg::item_t it);
		int hr, cnt, cc, cr;
		longint unsigned ds, ms, g1, g2, prob;
		gwps_pkg::result_t r;
		case (it.cmd)
			gwps_pkg::CMD_LOAD_PIXEL: if (it.index < WIN_CELLS)
				win_mem[it.index] = it.pixel_value < 0 ? 16'd0 : it.pixel_value;
			gwps_pkg::CMD_LOAD_CAND: if (it.index < CANDS_MAX)
				offs_mem[it.index] = it.cand_offset;
			gwps_pkg::CMD_COMPUTE: begin
				hr = it.half_range > HR_MAX ? HR_MAX : it.half_range;
				ds = it.deform_sigma == 0 ? 1 : it.deform_sigma;
				ms = map_sigma_q == 0 ? 1 : map_sigma_q;
				cnt = cand_count_q > CANDS_MAX ? CANDS_MAX : cand_count_q;
				for (int p1 = 0; p1 < cnt; p1++) begin
					cc = $signed(offs_mem[p1]);
					g1 = deform_gauss(cc, ds);
					for (int p2 = 0; p2 < cnt; p2++) begin
						cr = $signed(offs_mem[p2]);
						g2 = deform_gauss(cr, ds);
						prob = (g1 * g2) >> 32;
						r.fit_prior   = weighted_sum(cc, cr, hr, ms);
						r.deform_prob = prob > 65535 ? 16'hFFFF : prob[15:0];
						r.grad_row    = log_grad(cr, ds);
						r.grad_col    = log_grad(cc, ds);
						r.pos_row     = 16'((int'(it.center_row) + 1) * 16 + cr);
						r.pos_col     = 16'((int'(it.center_col) + 1) * 16 + cc);
						r.pair_index  = 6'(p1 * cnt + p2);
						r.last        = (p1 == cnt - 1 && p2 == cnt - 1);
						score_q.push_back(r);
					end
				end
			end
			default: ;
		endcase
	endtask

	// a compute beat stalls until its last result, so predict as soon as it is presented
	task automatic send_item(input gwps_pkg::item_t it);
		if (idle_on && $urandom_range(3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(15, 1)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_beat  <= it;
		predict_beat(it);
		do @(posedge clk); while (cmd_stall);
	endtask

	task automatic wait_idle();
		cmd_valid <= 1'b0;
		while (score_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == gwps_pkg::REG_MAP_SIGMA) map_sigma_q = value[11:0];
		else cand_count_q = value[3:0];
	endtask

	task automatic set_regs(input logic [31:0] sigma, input logic [31:0] count);
		wait_idle();
		write_reg(gwps_pkg::REG_MAP_SIGMA, sigma);
		write_reg(gwps_pkg::REG_NUM_CANDS, count);
	endtask

	function automatic gwps_pkg::item_t any_item();
		gwps_pkg::item_t it;
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		it = raw[$bits(gwps_pkg::item_t)-1:0];
		return it;
	endfunction

	function automatic gwps_pkg::item_t pixel_load(input int idx, input logic [15:0] v);
		gwps_pkg::item_t it;
		it = any_item();
		it.cmd = gwps_pkg::CMD_LOAD_PIXEL;
		it.index = 9'(idx);
		it.pixel_value = v;
		return it;
	endfunction

	function automatic gwps_pkg::item_t offset_load(input int idx, input logic [7:0] v);
		gwps_pkg::item_t it;
		it = any_item();
		it.cmd = gwps_pkg::CMD_LOAD_CAND;
		it.index = 9'(idx);
		it.cand_offset = v;
		return it;
	endfunction

	function automatic gwps_pkg::item_t compute_item(input int hr, input int ds,
			input int row, input int col);
		gwps_pkg::item_t it;
		it = any_item();
		it.cmd = gwps_pkg::CMD_COMPUTE;
		it.half_range = 4'(hr);
		it.deform_sigma = 12'(ds);
		it.center_row = 10'(row);
		it.center_col = 10'(col);
		return it;
	endfunction

	// every entry a compute can read gets written first
	task automatic test_fill_stores();
		for (int i = 0; i < WIN_CELLS; i++)
			send_item(pixel_load(i, 16'($urandom)));
		for (int i = 0; i < CANDS_MAX; i++)
			send_item(offset_load(i, 8'($urandom_range(80) - 40)));
	endtask

	task automatic test_directed();
		gwps_pkg::item_t it;
		send_item(pixel_load(0, 16'h7FFF));
		send_item(pixel_load(WIN_CELLS - 1, 16'h8000));
		send_item(pixel_load(1, 16'h0000));
		send_item(pixel_load(WIN_CELLS, 16'h1234));
		send_item(pixel_load(511, 16'h7FFF));
		send_item(offset_load(0, 8'h80));
		send_item(offset_load(1, 8'h7F));
		send_item(offset_load(CANDS_MAX, 8'h11));
		send_item(offset_load(511, 8'h22));
		it = any_item();
		it.cmd = CMD_NOP;
		send_item(it);
		set_regs(256, 2);
		send_item(compute_item(0, 1, 0, 0));
		send_item(compute_item(1, 4095, 1023, 1023));
		send_item(compute_item(1, 0, 512, 3));
		set_regs(4095, 1);
		send_item(compute_item(HR_MAX, 300, 10, 20));
		send_item(compute_item(15, 64, 1023, 0));
		set_regs(1, 8);
		send_item(compute_item(0, 256, 100, 200));
		set_regs(0, 0);
		send_item(compute_item(1, 256, 5, 5));
		set_regs(16, 15);
		send_item(compute_item(0, 32, 7, 9));
	endtask

	task automatic test_random(input int count);
		gwps_pkg::item_t it;
		int roll;
		for (int n = 0; n < count; n++) begin
			if (n % 6 == 5)
				set_regs($urandom_range(4095, 1), $urandom_range(4, 1));
			if (n == count - count / 4) idle_on = 1'b0;
			roll = $urandom_range(99);
			if (roll < 55) begin
				send_item(pixel_load($urandom_range(20) == 0 ? $urandom_range(511)
					: $urandom_range(WIN_CELLS - 1), 16'($urandom)));
			end else if (roll < 80) begin
				send_item(offset_load($urandom_range(20) == 0 ? $urandom_range(511)
					: $urandom_range(CANDS_MAX - 1), 8'($urandom)));
			end else if (roll < 90) begin
				send_item(compute_item($urandom_range(9) < 7 ? $urandom_range(1) : 2,
					$urandom_range(4095), $urandom_range(1023), $urandom_range(1023)));
			end else if (roll < 93) begin
				it = any_item();
				it.cmd = CMD_NOP;
				send_item(it);
			end else begin
				send_item(pixel_load($urandom_range(WIN_CELLS - 1),
					16'($urandom_range(32767))));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		cmd_valid = 1'b0; cmd_beat = '0; res_stall = 1'b0;
		errors = 0; idle_on = 1'b1; stall_left = 0; cycles = 0;
		map_sigma_q = 12'd256;
		cand_count_q = 4'd8;
		foreach (win_mem[i]) win_mem[i] = '0;
		foreach (offs_mem[i]) offs_mem[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_stores();
		test_directed();
		set_regs(256, 2);
		test_random(16);
		wait_idle();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
